// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared constants, command codes and types for the text console writer.
// Used by tcw_front, tcw_queue, tcw_back and text_console_writer.
// No dependencies.
package tcw_pkg;

   // screen geometry
   localparam int COLS         = 80;
   localparam int ROWS         = 25;
   localparam int CELLS        = ROWS * COLS;
   localparam int SCROLL_CELLS = (ROWS - 1) * COLS;

   // field widths
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = $clog2(CELLS);

   // command queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request op codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_READ,
      CMD_SCROLL,
      CMD_CLEAR
   } cmd_kind_type;

   // one classified command; cell_data holds {attribute, character}
   typedef struct packed {
      cmd_kind_type           kind;
      logic                   put_after;   // write cell at addr once scroll is done
      logic [ADDR_W-1:0]      addr;
      logic [CELL_W-1:0]      cell_data;
      logic [ROW_W-1:0]       cur_row;     // cursor after the item
      logic [COL_W-1:0]       cur_col;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage

// ===== rtl/tcw_front.sv =====
// tcw_front: accepts requests, keeps cursor and colour, classifies each item into
// a command for the back end. Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              q_full,
   input  logic [OP_W-1:0]   req_op,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_cell_row,
   input  logic [COL_W-1:0]  req_cell_col,
   input  logic              csr_we,
   input  logic [ATTR_W-1:0] csr_wdata,
   output logic              push,
   output cmd_type           push_cmd
);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ATTR_W-1:0] color_ff;
   logic [ROW_W-1:0]  addr_row;
   logic [COL_W-1:0]  addr_col;
   logic              at_last;

   assign push    = start & ~q_full;
   assign at_last = (row_ff == ROW_W'(ROWS - 1));

   always_comb begin
      row_in             = row_ff;
      col_in             = col_ff;
      addr_row           = row_ff;
      addr_col           = col_ff;
      push_cmd.kind      = CMD_NOP;
      push_cmd.put_after = 1'b0;
      push_cmd.cell_data = {color_ff, req_char_code};
      unique case (req_op)
         OP_PUT: begin
            if (req_char_code == NEWLINE_CODE) begin
               col_in = '0;
               if (at_last) begin
                  push_cmd.kind = CMD_SCROLL;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else if (col_ff >= COL_W'(COLS)) begin
               // line full: newline first, then write at column 0
               col_in   = COL_W'(1);
               addr_col = '0;
               if (at_last) begin
                  push_cmd.kind      = CMD_SCROLL;
                  push_cmd.put_after = 1'b1;
               end else begin
                  row_in        = row_ff + 1'b1;
                  addr_row      = row_ff + 1'b1;
                  push_cmd.kind = CMD_WRITE;
               end
            end else begin
               col_in        = col_ff + 1'b1;
               push_cmd.kind = CMD_WRITE;
            end
         end
         OP_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
         end
         OP_READ: begin
            addr_row = req_cell_row;
            addr_col = req_cell_col;
            if (req_cell_row < ROW_W'(ROWS) && req_cell_col < COL_W'(COLS)) begin
               push_cmd.kind = CMD_READ;
            end
         end
         default: begin
            push_cmd.kind = CMD_NOP;
         end
      endcase
      push_cmd.addr    = ADDR_W'(addr_row) * ADDR_W'(COLS) + ADDR_W'(addr_col);
      push_cmd.cur_row = row_in;
      push_cmd.cur_col = col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         color_ff <= ATTR_RESET;
      end else begin
         if (push) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_we) begin
            color_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== rtl/tcw_queue.sv =====
// tcw_queue: short FIFO of classified commands between front and back end.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output logic       full,
   output q_head_type head
);

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];
   assign do_pop     = pop & head.valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/tcw_back.sv =====
// tcw_back: carries out commands on the cell store (write, read, scroll, clear)
// and drives the result registers. Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  q_head_type        head,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [CHAR_W-1:0] rsp_read_char,
   output logic [ATTR_W-1:0] rsp_read_color
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_SCR_RD = 6'b000100,
      ST_SCR_WR = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;

   logic              we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data;

   logic              emit;
   cmd_type           emit_cmd;
   logic [CELL_W-1:0] emit_cell;

   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [CELL_W-1:0] rsp_cell_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      ptr_in    = ptr_ff;
      pop       = 1'b0;
      we        = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = {cmd_ff.cell_data[CELL_W-1:CHAR_W], SPACE_CODE};
      rd_addr   = head.cmd.addr;
      emit      = 1'b0;
      emit_cmd  = cmd_ff;
      emit_cell = '0;
      unique case (state_ff)
         ST_IDLE: begin
            emit_cmd = head.cmd;
            if (head.valid) begin
               pop    = 1'b1;
               cmd_in = head.cmd;
               ptr_in = '0;
               unique case (head.cmd.kind)
                  CMD_WRITE: begin
                     we      = 1'b1;
                     wr_addr = head.cmd.addr;
                     wr_data = head.cmd.cell_data;
                     emit    = 1'b1;
                  end
                  CMD_READ:   state_in = ST_READ;
                  CMD_SCROLL: state_in = ST_SCR_RD;
                  CMD_CLEAR:  state_in = ST_FILL;
                  default:    emit     = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            emit      = 1'b1;
            emit_cell = rd_data_ff;
            state_in  = ST_IDLE;
         end
         ST_SCR_RD: begin
            rd_addr  = ptr_ff + ADDR_W'(COLS);
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            we      = 1'b1;
            wr_data = rd_data_ff;
            if (ptr_ff == ADDR_W'(SCROLL_CELLS - 1)) begin
               ptr_in   = ADDR_W'(SCROLL_CELLS);
               state_in = ST_FILL;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_SCR_RD;
            end
         end
         ST_FILL: begin
            we = 1'b1;
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (cmd_ff.put_after) begin
               we      = 1'b1;
               wr_addr = cmd_ff.addr;
               wr_data = cmd_ff.cell_data;
            end
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ptr_ff <= ptr_in;
      if (emit) begin
         rsp_row_ff  <= emit_cmd.cur_row;
         rsp_col_ff  <= emit_cmd.cur_col;
         rsp_cell_ff <= emit_cell;
      end
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_read_char  = rsp_cell_ff[CHAR_W-1:0];
   assign rsp_read_color = rsp_cell_ff[CELL_W-1:CHAR_W];

endmodule

// ===== rtl/text_console_writer.sv =====
// A result strobe is registered after the back end pops the command; a read first waits
// for the registered cell store read, and a scroll or a clear for its sweep of the store.
// Throughput: one put per cycle while the queue drains; the single-port cell store sets it.
// busy rises only when the 4-entry command queue is full; results cannot be stalled.
// Reset (synchronous, active high) clears cursor, colour (to 15), queue and FSM;
// the cell store is not cleared and holds undefined data until written.
module text_console_writer import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_op,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_cell_row,
   input  logic [COL_W-1:0]  req_cell_col,
   // colour register
   input  logic              csr_we,
   input  logic [ATTR_W-1:0] csr_wdata,
   // result channel
   output logic              rsp_strobe,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [CHAR_W-1:0] rsp_read_char,
   output logic [ATTR_W-1:0] rsp_read_color
);

   logic       push;
   logic       pop;
   logic       q_full;
   cmd_type    push_cmd;
   q_head_type head;

   // busy only reflects the queue; the back end stalls independently
   assign busy = q_full;

   // front: cursor tracking and classification at transfer time
   tcw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .q_full        (q_full),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_cell_row  (req_cell_row),
      .req_cell_col  (req_cell_col),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // decoupling queue
   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   // back: cell store and long scroll / clear sweeps
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_color (rsp_read_color)
   );

   // cursor reported with a result has its row on screen and its column at most COLS
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cursor_row < ROW_W'(ROWS)))
      else $error("result cursor row out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cursor_col <= COL_W'(COLS)))
      else $error("result cursor column out of range");

   // no stray result straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   // a full queue must present a valid head to the back end
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      busy |-> head.valid)
      else $error("queue full but head not valid");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for text_console_writer, with its own screen and cursor tracker.
// Depends on tcw_pkg (geometry, widths, op codes) and the text_console_writer RTL.
module tb;
   import tcw_pkg::*;

   // op code 3 is not decoded by the block; it must just report the cursor
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int IDLE_LIMIT  = 20000;   // must outlast a full scroll, which has no transfer
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 205;
   localparam int TAIL_CYCLES = 10;
   localparam int REPORT_MAX  = 10;

   // what one result carries
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAR_W-1:0] rd_char;
      logic [ATTR_W-1:0] rd_attr;
   } console_status_type;

   // Tracks the screen, cursor and colour as the block should, and holds the
   // status words still owed by the block, oldest first.
   class console_scoreboard;
      logic [CELL_W-1:0]  cells [CELLS];
      bit                 written [CELLS];
      int                 row;
      int                 col;
      logic [ATTR_W-1:0]  attr;
      console_status_type owed_status [$];
      int                 mismatches;

      function new();
         row        = 0;
         col        = 0;
         attr       = ATTR_RESET;
         mismatches = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void blank_row(int r);
         for (int c = 0; c < COLS; c++) begin
            cells[r * COLS + c]   = {attr, SPACE_CODE};
            written[r * COLS + c] = 1'b1;
         end
      endfunction

      // carriage return plus line feed; scrolls when already on the bottom row
      function void next_line();
         col = 0;
         if (row < ROWS - 1) begin
            row++;
         end else begin
            for (int i = 0; i < SCROLL_CELLS; i++) begin
               cells[i]   = cells[i + COLS];
               written[i] = written[i + COLS];
            end
            blank_row(ROWS - 1);
         end
      endfunction

      // a read here never touches a cell holding undefined data
      function bit readable(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
         return (r >= ROWS) || (c >= COLS) || written[r * COLS + c];
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
         console_status_type s;
         int                 idx;
         s.rd_char = '0;
         s.rd_attr = '0;
         case (op)
            OP_PUT: begin
               if (ch == NEWLINE_CODE) begin
                  next_line();
               end else begin
                  if (col >= COLS) next_line();
                  idx          = row * COLS + col;
                  cells[idx]   = {attr, ch};
                  written[idx] = 1'b1;
                  col++;
               end
            end
            OP_CLEAR: begin
               for (int i = 0; i < ROWS; i++) blank_row(i);
            end
            OP_READ: begin
               if (r < ROWS && c < COLS) {s.rd_attr, s.rd_char} = cells[r * COLS + c];
            end
            default: ;
         endcase
         s.row = ROW_W'(row);
         s.col = COL_W'(col);
         owed_status.push_back(s);
      endfunction

      function void check_result(console_status_type got);
         console_status_type want;
         if (owed_status.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("result with nothing owed: row %0d col %0d char %02h attr %02h",
                        got.row, got.col, got.rd_char, got.rd_attr);
         end else begin
            want = owed_status.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch: exp %0d/%0d %02h/%02h, got %0d/%0d %02h/%02h",
                           want.row, want.col, want.rd_char, want.rd_attr,
                           got.row, got.col, got.rd_char, got.rd_attr);
            end
         end
      endfunction

      function int pending();
         return owed_status.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_op;
   logic [CHAR_W-1:0] req_char_code;
   logic [ROW_W-1:0]  req_cell_row;
   logic [COL_W-1:0]  req_cell_col;
   logic              csr_we;
   logic [ATTR_W-1:0] csr_wdata;
   logic              rsp_strobe;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [COL_W-1:0]  rsp_cursor_col;
   logic [CHAR_W-1:0] rsp_read_char;
   logic [ATTR_W-1:0] rsp_read_color;

   console_scoreboard sb;
   int                idle_cycles = 0;
   bit                gapless;        // back-to-back transfers for a whole phase
   bit                filling_line;   // no newlines until the line is full

   text_console_writer dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_color (rsp_read_color)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is a transfer. Outputs are
   // read straight after the edge, i.e. the values held during the cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result({rsp_cursor_row, rsp_cursor_col, rsp_read_char, rsp_read_color});
   end

   // Watchdog: any transfer on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[text_console_writer] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One request transfer. start stays high on return, so a following item
   // with no gap goes out on the very next cycle. The request is noted here,
   // not in a monitor, so the tracker is up to date before the next is drawn.
   task automatic issue(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                        input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_char_code <= ch;
      req_cell_row  <= r;
      req_cell_col  <= c;
      do @(posedge clock); while (busy);
      sb.note_request(op, ch, r, c);
   endtask

   // sender stops and waits for every owed result
   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic write_colour(input logic [ATTR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.attr   = v;
   endtask

   // Mostly text: runs of characters with sparse newlines, plus runs that
   // fill a line to the edge so line-full wraps and newlines on a full line
   // happen often. Reads lean towards the rows near the cursor.
   task automatic random_item();
      int                pick;
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  r;
      logic [COL_W-1:0]  c;
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom);
      r    = ROW_W'($urandom);
      c    = COL_W'($urandom);
      if (pick < 2) begin
         op = OP_CLEAR;
      end else if (pick < 4) begin
         op = OP_UNUSED;
      end else if (pick < 24) begin
         op = OP_READ;
         case ($urandom_range(0, 3))
            0:       ;   // anything the field allows, out of range included
            1:       r = ROW_W'((sb.row > 0 && $urandom_range(0, 1)) ? sb.row - 1 : sb.row);
            default: r = ROW_W'($urandom_range(0, ROWS - 1));
         endcase
         if ($urandom_range(0, 4) != 0) c = COL_W'($urandom_range(0, COLS - 1));
         // cells still undefined since reset are steered off-screen
         if (!sb.readable(r, c)) r = ROW_W'($urandom_range(ROWS, 2**ROW_W - 1));
      end else begin
         op = OP_PUT;
         if (sb.col >= COLS) begin
            filling_line = 1'b0;
            if ($urandom_range(0, 2) == 0) ch = NEWLINE_CODE;
         end else if (filling_line) begin
            if (ch == NEWLINE_CODE) ch = ~ch;
         end else if ($urandom_range(0, 99) < 5) begin
            ch = NEWLINE_CODE;
         end else if ($urandom_range(0, 99) < 3) begin
            filling_line = 1'b1;
         end
      end
      issue(op, ch, r, c);
   endtask

   initial begin
      logic [ATTR_W-1:0] colour;
      sb            = new();
      gapless       = 1'b0;
      filling_line  = 1'b0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_op        <= OP_PUT;
      req_char_code <= '0;
      req_cell_row  <= '0;
      req_cell_col  <= '0;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset colour, character extremes, newlines, every op,
      // off-screen reads and a clear that leaves the cursor alone
      issue(OP_PUT,    8'h41,        '0,    '0);
      issue(OP_READ,   '0,           5'd0,  7'd0);
      issue(OP_PUT,    8'h00,        '0,    '0);
      issue(OP_PUT,    8'hFF,        '0,    '0);
      issue(OP_READ,   '0,           5'd0,  7'd2);
      issue(OP_READ,   '0,           5'd0,  7'd1);
      issue(OP_PUT,    NEWLINE_CODE, '0,    '0);
      issue(OP_PUT,    NEWLINE_CODE, '0,    '0);
      issue(OP_UNUSED, 8'hFF,        '1,    '1);
      issue(OP_READ,   '0,           5'd31, 7'd0);
      issue(OP_READ,   '0,           5'd0,  7'd127);
      issue(OP_READ,   '0,           5'd24, 7'd80);
      issue(OP_READ,   '0,           5'd25, 7'd79);
      issue(OP_CLEAR,  '1,           '1,    '1);
      issue(OP_READ,   '0,           5'd24, 7'd79);
      issue(OP_READ,   '0,           5'd0,  7'd0);
      issue(OP_PUT,    8'h7F,        '0,    '0);
      issue(OP_PUT,    8'h80,        '0,    '0);
      issue(OP_READ,   '1,           5'd2,  7'd1);
      issue(OP_PUT,    NEWLINE_CODE, '0,    '0);
      drain();

      // random phases; colour changes only with the block idle, both
      // extremes first. Two phases run with no gaps at all.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)      colour = '0;
         else if (p == 1) colour = '1;
         else             colour = ATTR_W'($urandom);
         write_colour(colour);
         gapless = (p == 2 || p == 5);
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[text_console_writer] OK");
      end else begin
         $display("[text_console_writer] ERROR");
      end
      $finish;
   end

endmodule
